// ===== rtl/paged_shelf_rect_packer_core_macros.svh =====
// Assertion helpers used by the checker file of the rect packer.
`ifndef PAGED_SHELF_RECT_PACKER_CORE_MACROS_SVH
`define PAGED_SHELF_RECT_PACKER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PSRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rect packer assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define PSRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rect packer assertion failed");

// Next-cycle implication that is also checked across reset.
`define PSRP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rect packer assertion failed");

`endif

// ===== rtl/psrp_pkg.sv =====
package psrp_pkg;

    // Field widths of the item interface.
    localparam int DIM_W  = 12;
    localparam int POS_W  = 11;
    localparam int PAGE_W = 2;

    // Layout constants of a page.
    localparam int PAD          = 1;
    localparam int WHITE_PATCH  = 4;
    localparam int FRESH_X      = WHITE_PATCH + PAD;
    localparam int FRESH_Y      = PAD;
    localparam int FRESH_ROW    = WHITE_PATCH;
    localparam int FRESH_NEXT_Y = FRESH_Y + FRESH_ROW + PAD;

    typedef enum logic [1:0] {
        ST_PLACED     = 2'd0,
        ST_BAD_SIZE   = 2'd1,
        ST_FULL       = 2'd2,
        ST_RESET_DONE = 2'd3
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_RESET  = 1'b1
    } t_command;

    typedef struct packed {
        t_status             status;
        logic [PAGE_W-1:0]   page_index;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
    } t_result;

endpackage

// ===== rtl/psrp_place.sv =====
module psrp_place
    import psrp_pkg::*;
#(
    parameter int ATLAS_SIZE = 2048,
    parameter int PAGE_COUNT = 4,
    localparam int CW = $clog2(ATLAS_SIZE + 1),
    localparam int PW = $clog2(PAGE_COUNT + 1)
) (
    input  t_command           i_command,
    input  logic [DIM_W-1:0]   i_glyph_width,
    input  logic [DIM_W-1:0]   i_glyph_height,
    input  logic [PW-1:0]      i_open_pages,
    input  logic [CW-1:0]      i_cursor_x,
    input  logic [CW-1:0]      i_cursor_y,
    input  logic [DIM_W-1:0]   i_row_height,
    input  logic               i_first_page_made,
    output logic [PW-1:0]      o_open_pages,
    output logic [CW-1:0]      o_cursor_x,
    output logic [CW-1:0]      o_cursor_y,
    output logic [DIM_W-1:0]   o_row_height,
    output logic               o_first_page_made,
    output t_result            o_result
);

    // Sums of a cursor and a size, with room for the carry.
    localparam int SW = ((CW > DIM_W) ? CW : DIM_W) + 2;
    localparam logic [SW-1:0] SIZE = SW'(ATLAS_SIZE);

    logic [SW-1:0] gw_e;
    logic [SW-1:0] gh_e;
    logic [PW-1:0] eff_open;
    logic [SW-1:0] eff_cx;
    logic [SW-1:0] eff_cy;
    logic [DIM_W-1:0] eff_rh;
    logic [SW-1:0] row_end;
    logic [SW-1:0] row_bot;
    logic [SW-1:0] next_y;
    logic [SW-1:0] new_bot;
    logic [SW-1:0] fresh_end;
    logic [SW-1:0] pad_end;
    logic [SW-1:0] fresh_bot;
    logic [SW-1:0] place_x;
    logic [SW-1:0] place_y;
    logic [PW+1:0] page_ext;
    logic          bad_size;
    logic          fit_row;
    logic          fit_new;
    logic          fresh_row;
    logic          fresh_new;
    logic          page_left;

    assign gw_e = SW'(i_glyph_width);
    assign gh_e = SW'(i_glyph_height);

    // With no page open, an insert sees a freshly started page 0.
    assign eff_open = (i_open_pages == '0) ? PW'(1) : i_open_pages;
    assign eff_cx   = (i_open_pages == '0) ? SW'(FRESH_X) : SW'(i_cursor_x);
    assign eff_cy   = (i_open_pages == '0) ? SW'(FRESH_Y) : SW'(i_cursor_y);
    assign eff_rh   = (i_open_pages == '0) ? DIM_W'(FRESH_ROW) : i_row_height;

    assign bad_size = (i_glyph_width == '0) || (i_glyph_height == '0) ||
                      (gw_e + SW'(2 * PAD) > SIZE) || (gh_e + SW'(2 * PAD) > SIZE);

    // Current row.
    assign row_end = eff_cx + gw_e + SW'(PAD);
    assign row_bot = eff_cy + gh_e + SW'(PAD);
    assign fit_row = (row_end <= SIZE) && (row_bot <= SIZE);

    // New row below the current one; an empty row still advances by the pad.
    assign next_y  = eff_cy + SW'(eff_rh) + SW'(PAD);
    assign new_bot = next_y + gh_e + SW'(PAD);
    assign fit_new = (new_bot <= SIZE);

    // A fresh page is the same for every page, so one check covers all retries.
    assign fresh_end = SW'(FRESH_X) + gw_e + SW'(PAD);
    assign fresh_bot = SW'(FRESH_NEXT_Y) + gh_e + SW'(PAD);
    assign pad_end   = SW'(PAD) + gw_e + SW'(PAD);
    assign fresh_row = (fresh_end <= SIZE);
    assign fresh_new = (fresh_bot <= SIZE);
    assign page_left = (eff_open < PW'(PAGE_COUNT));

    // Placement decision and next state.
    always_comb begin
        o_open_pages      = i_open_pages;
        o_cursor_x        = i_cursor_x;
        o_cursor_y        = i_cursor_y;
        o_row_height      = i_row_height;
        o_first_page_made = i_first_page_made;
        o_result          = '0;
        o_result.status   = ST_PLACED;
        place_x           = '0;
        place_y           = '0;
        page_ext          = '0;

        if (i_command == CMD_RESET) begin
            o_result.status = ST_RESET_DONE;
            if (i_first_page_made) begin
                o_open_pages = PW'(1);
                o_cursor_x   = CW'(FRESH_X);
                o_cursor_y   = CW'(FRESH_Y);
                o_row_height = DIM_W'(FRESH_ROW);
            end else begin
                o_open_pages = '0;
            end
        end else if (bad_size) begin
            o_result.status = ST_BAD_SIZE;
        end else begin
            o_first_page_made = 1'b1;
            o_open_pages      = eff_open;
            o_cursor_x        = CW'(eff_cx);
            o_cursor_y        = CW'(eff_cy);
            o_row_height      = eff_rh;

            if (fit_row) begin
                place_x      = eff_cx;
                place_y      = eff_cy;
                o_cursor_x   = CW'(row_end);
                o_row_height = (i_glyph_height > eff_rh) ? i_glyph_height : eff_rh;
            end else if (fit_new) begin
                place_x      = SW'(PAD);
                place_y      = next_y;
                o_cursor_x   = CW'(pad_end);
                o_cursor_y   = CW'(next_y);
                o_row_height = i_glyph_height;
            end else if (!page_left) begin
                o_result.status = ST_FULL;
            end else if (fresh_row || fresh_new) begin
                o_open_pages = eff_open + PW'(1);
                if (fresh_row) begin
                    place_x      = SW'(FRESH_X);
                    place_y      = SW'(FRESH_Y);
                    o_cursor_x   = CW'(fresh_end);
                    o_cursor_y   = CW'(FRESH_Y);
                    o_row_height = (i_glyph_height > DIM_W'(FRESH_ROW)) ?
                                   i_glyph_height : DIM_W'(FRESH_ROW);
                end else begin
                    place_x      = SW'(PAD);
                    place_y      = SW'(FRESH_NEXT_Y);
                    o_cursor_x   = CW'(pad_end);
                    o_cursor_y   = CW'(FRESH_NEXT_Y);
                    o_row_height = i_glyph_height;
                end
            end else begin
                // Every remaining page is opened in turn and none fits.
                o_result.status = ST_FULL;
                o_open_pages    = PW'(PAGE_COUNT);
                o_cursor_x      = CW'(FRESH_X);
                o_cursor_y      = CW'(FRESH_Y);
                o_row_height    = DIM_W'(FRESH_ROW);
            end

            if (o_result.status == ST_PLACED) begin
                page_ext            = (PW + 2)'(o_open_pages) - (PW + 2)'(1);
                o_result.page_index = page_ext[PAGE_W-1:0];
                o_result.pos_x      = place_x[POS_W-1:0];
                o_result.pos_y      = place_y[POS_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/paged_shelf_rect_packer_core.sv =====
// An item passes through the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; the placement state is
// read and rewritten in the same cycle that the item moves to the result register.
// Reset (i_rst_n low, synchronous): no pages open, cursors cleared, both registers empty.
module paged_shelf_rect_packer_core
    import psrp_pkg::*;
#(
    parameter int ATLAS_SIZE = 2048,
    parameter int PAGE_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // glyph_width [11:0], glyph_height [23:12]
    input  logic [0:0]  i_s_tuser,   // command [0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // page_index [1:0], pos_x [12:2], pos_y [23:13]
    output logic [1:0]  o_m_tuser    // status [1:0]
);

    localparam int CW = $clog2(ATLAS_SIZE + 1);
    localparam int PW = $clog2(PAGE_COUNT + 1);

    logic             r_in_valid;
    t_command         r_command;
    logic [DIM_W-1:0] r_glyph_width;
    logic [DIM_W-1:0] r_glyph_height;
    logic             r_out_valid;
    t_result          r_result;

    logic [PW-1:0]    r_open_pages;
    logic [CW-1:0]    r_cursor_x;
    logic [CW-1:0]    r_cursor_y;
    logic [DIM_W-1:0] r_row_height;
    logic             r_first_page_made;

    logic [PW-1:0]    n_open_pages;
    logic [CW-1:0]    n_cursor_x;
    logic [CW-1:0]    n_cursor_y;
    logic [DIM_W-1:0] n_row_height;
    logic             n_first_page_made;
    t_result          n_result;

    logic             advance;

    // The held item moves to the result register whenever that register is free.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    psrp_place #(
        .ATLAS_SIZE (ATLAS_SIZE),
        .PAGE_COUNT (PAGE_COUNT)
    ) u_place (
        .i_command         (r_command),
        .i_glyph_width     (r_glyph_width),
        .i_glyph_height    (r_glyph_height),
        .i_open_pages      (r_open_pages),
        .i_cursor_x        (r_cursor_x),
        .i_cursor_y        (r_cursor_y),
        .i_row_height      (r_row_height),
        .i_first_page_made (r_first_page_made),
        .o_open_pages      (n_open_pages),
        .o_cursor_x        (n_cursor_x),
        .o_cursor_y        (n_cursor_y),
        .o_row_height      (n_row_height),
        .o_first_page_made (n_first_page_made),
        .o_result          (n_result)
    );

    // Valid flags and placement state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_open_pages      <= '0;
            r_cursor_x        <= '0;
            r_cursor_y        <= '0;
            r_row_height      <= '0;
            r_first_page_made <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid       <= 1'b1;
                r_open_pages      <= n_open_pages;
                r_cursor_x        <= n_cursor_x;
                r_cursor_y        <= n_cursor_y;
                r_row_height      <= n_row_height;
                r_first_page_made <= n_first_page_made;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_command      <= t_command'(i_s_tuser[0]);
            r_glyph_width  <= i_s_tdata[11:0];
            r_glyph_height <= i_s_tdata[23:12];
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_result.pos_y, r_result.pos_x, r_result.page_index};
    assign o_m_tuser  = r_result.status;

endmodule

// ===== rtl/psrp_checker.sv =====
`include "paged_shelf_rect_packer_core_macros.svh"

module psrp_checker
    import psrp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // A result that is not a placement carries no page or position.
    `PSRP_ASSERT_IMP(a_empty_payload, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != ST_PLACED), o_m_tdata == '0)

    // The input side only stalls behind a full, stalled output.
    `PSRP_ASSERT_IMP(a_ready_low_only_when_stalled, i_clk, i_rst_n,
        !o_s_tready, o_m_tvalid && !i_m_tready)

    // A stalled result holds its value.
    `PSRP_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // Reset empties the output register.
    `PSRP_ASSERT_NXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind paged_shelf_rect_packer_core psrp_checker u_psrp_checker (.*);
